### design/avnal_pkg.sv
`default_nettype none
package avnal_pkg;

  // codec codes
  localparam logic [1:0] CODEC_UNKNOWN = 2'd0;
  localparam logic [1:0] CODEC_H264    = 2'd1;
  localparam logic [1:0] CODEC_HEVC    = 2'd2;

  // parameter set codes
  localparam logic [1:0] PARAM_NONE = 2'd0;
  localparam logic [1:0] PARAM_VPS  = 2'd1;
  localparam logic [1:0] PARAM_SPS  = 2'd2;
  localparam logic [1:0] PARAM_PPS  = 2'd3;

  // request codes
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // nal header types
  localparam logic [5:0] HEVC_VPS_TYPE = 6'd32;
  localparam logic [5:0] HEVC_SPS_TYPE = 6'd33;
  localparam logic [5:0] HEVC_PPS_TYPE = 6'd34;
  localparam logic [4:0] AVC_SPS_TYPE  = 5'd7;
  localparam logic [4:0] AVC_PPS_TYPE  = 5'd8;

  localparam logic [3:0] PREFIX_LEN      = 4'd8;
  localparam logic [2:0] LEN_FIELD_LAST  = 3'd3;
  localparam logic [2:0] PHASE_HEADER    = 3'd4;
  localparam int         FRAME_FIELD_W   = 24;
  localparam logic [7:0] START_CODE_ZERO = 8'h00;
  localparam logic [7:0] START_CODE_ONE  = 8'h01;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  data_byte;
    logic        first_of_frame;
    logic [23:0] frame_bytes;
  } req_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] codec_kind;
    logic [5:0] unit_type;
    logic [1:0] param_kind;
    logic       sets_ready;
    logic       scan_stopped;
    logic       frame_end;
    logic       run_last;
  } rsp_item_t;

  typedef struct packed {
    logic [1:0] codec_kind;
    logic [5:0] unit_type;
    logic [1:0] param_kind;
  } hdr_info_t;

endpackage
`default_nettype wire

### design/avcc_nal_scanner_annexb_converter_unit.sv
`default_nettype none
// Length-prefixed NAL scanner and Annex B converter. One frame byte enters per
// item on the req channel; each item leaves zero, one or four result items on
// the rsp channel (four only where an HEVC length field is rewritten to the
// 00 00 00 01 start code). An item is held in an input register, worked by
// combinational logic against the scanner state and loaded into a result
// register that drains one result per cycle while rsp_stall is low. Items are
// taken every cycle while results are single and the receiver does not stall;
// after a start code the next item waits in the input register until the
// last start-code byte is taken. Clear requests, prefix bytes and stray
// bytes outside a frame give no result. The one register, has_time_prefix, is
// written through cfg_valid/cfg_data, always ready.
module avcc_nal_scanner_annexb_converter_unit
  import avnal_pkg::*;
#(
  parameter int FRAME_LEN_BITS = 24
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_item_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_item_t      rsp,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  // frame length as kept: the field cut to the smaller of FRAME_LEN_BITS and FRAME_FIELD_W
  localparam int BL_W = (FRAME_LEN_BITS < FRAME_FIELD_W) ? FRAME_LEN_BITS : FRAME_FIELD_W;

  // configuration
  logic has_time_prefix;

  // input register
  logic      inq_valid;
  req_item_t inq;

  // scanner state
  logic [1:0]      codec_seen, codec_seen_next;
  logic [BL_W-1:0] bytes_left, bytes_left_next;
  logic [3:0]      prefix_left, prefix_left_next;
  logic [2:0]      length_phase, length_phase_next;
  logic [31:0]     length_bytes, length_bytes_next;
  logic [BL_W-1:0] unit_left, unit_left_next;
  logic [5:0]      current_type, current_type_next;
  logic [1:0]      current_param, current_param_next;
  logic            stopped, stopped_next;
  logic            have_vps, have_vps_next;
  logic            have_sps, have_sps_next;
  logic            have_pps, have_pps_next;

  // result register: one byte or a whole start code plus shared status
  logic [1:0] idx;
  logic [7:0] b_byte;
  logic       b_four;
  logic [1:0] b_codec;
  logic [5:0] b_type;
  logic [1:0] b_param;
  logic       b_ready;
  logic       b_stop;
  logic       b_fend;

  // item work
  logic            emit;
  logic            emit_four;
  logic            hevc;
  logic [BL_W-1:0] rem;
  logic [31:0]     lb_new;
  logic            ready_next;
  hdr_info_t       hinfo;

  // handshake
  logic rsp_last;
  logic drain;
  logic fire;

  avnal_hdr_class u_hdr (
    .hdr        (inq.data_byte),
    .codec_seen (codec_seen),
    .info       (hinfo)
  );

  always_comb begin
    codec_seen_next    = codec_seen;
    bytes_left_next    = bytes_left;
    prefix_left_next   = prefix_left;
    length_phase_next  = length_phase;
    length_bytes_next  = length_bytes;
    unit_left_next     = unit_left;
    current_type_next  = current_type;
    current_param_next = current_param;
    stopped_next       = stopped;
    have_vps_next      = have_vps;
    have_sps_next      = have_sps;
    have_pps_next      = have_pps;
    emit      = 1'b0;
    emit_four = 1'b0;
    hevc      = (codec_seen == CODEC_HEVC);
    rem       = '0;
    lb_new    = {length_bytes[23:0], inq.data_byte};

    if (inq.req_type == REQ_CLEAR) begin
      // new sender: forget codec, sets and frame
      codec_seen_next    = CODEC_UNKNOWN;
      bytes_left_next    = '0;
      prefix_left_next   = '0;
      length_phase_next  = '0;
      length_bytes_next  = '0;
      unit_left_next     = '0;
      current_type_next  = '0;
      current_param_next = PARAM_NONE;
      stopped_next       = 1'b0;
      have_vps_next      = 1'b0;
      have_sps_next      = 1'b0;
      have_pps_next      = 1'b0;
    end else begin
      if (inq.first_of_frame) begin
        bytes_left_next    = inq.frame_bytes[BL_W-1:0];
        prefix_left_next   = has_time_prefix ? PREFIX_LEN : 4'd0;
        length_phase_next  = '0;
        length_bytes_next  = '0;
        unit_left_next     = '0;
        current_type_next  = '0;
        current_param_next = PARAM_NONE;
        stopped_next       = 1'b0;
      end
      lb_new = {length_bytes_next[23:0], inq.data_byte};
      // bytes outside a frame are ignored
      if (bytes_left_next != '0) begin
        rem = bytes_left_next;
        bytes_left_next = rem - 1'b1;
        if (prefix_left_next != 4'd0) begin
          prefix_left_next = prefix_left_next - 4'd1;
        end else if (stopped_next ||
                     (unit_left_next == '0 && length_phase_next == 3'd0 && rem < BL_W'(4))) begin
          // after a stop, or a tail too short for a length field
          emit = !hevc;
        end else if (unit_left_next == '0) begin
          // length field byte
          if (length_phase_next == 3'd0) begin
            current_type_next  = '0;
            current_param_next = PARAM_NONE;
          end
          emit = !hevc;
          if (length_phase_next == LEN_FIELD_LAST) begin
            if (lb_new == 32'd0 || lb_new > 32'(bytes_left_next)) begin
              stopped_next      = 1'b1;
              length_phase_next = 3'd0;
            end else begin
              unit_left_next    = lb_new[BL_W-1:0];
              length_phase_next = PHASE_HEADER;
              if (hevc) begin
                emit      = 1'b1;
                emit_four = 1'b1;
              end
            end
            length_bytes_next = '0;
          end else begin
            length_bytes_next = lb_new;
            length_phase_next = length_phase_next + 3'd1;
          end
        end else if (length_phase_next == PHASE_HEADER) begin
          // unit header: sniff codec and classify
          codec_seen_next    = hinfo.codec_kind;
          current_type_next  = hinfo.unit_type;
          current_param_next = hinfo.param_kind;
          case (hinfo.param_kind)
            PARAM_VPS: have_vps_next = 1'b1;
            PARAM_SPS: have_sps_next = 1'b1;
            PARAM_PPS: have_pps_next = 1'b1;
            default:   ;
          endcase
          length_phase_next = 3'd0;
          unit_left_next    = unit_left_next - 1'b1;
          emit              = 1'b1;
        end else begin
          unit_left_next = unit_left_next - 1'b1;
          emit           = 1'b1;
        end
      end
    end
    ready_next = have_sps_next && have_pps_next &&
                 (codec_seen_next != CODEC_HEVC || have_vps_next);
  end

  // result drain and input advance
  assign rsp_last  = !b_four || (idx == 2'd3);
  assign drain     = rsp_valid && !rsp_stall && rsp_last;
  assign fire      = inq_valid && (!rsp_valid || drain);
  assign req_stall = inq_valid && !fire;
  assign cfg_ready = 1'b1;

  always_comb begin
    rsp.out_byte     = b_four ? ((idx == 2'd3) ? START_CODE_ONE : START_CODE_ZERO) : b_byte;
    rsp.codec_kind   = b_codec;
    rsp.unit_type    = b_type;
    rsp.param_kind   = b_param;
    rsp.sets_ready   = b_ready;
    rsp.scan_stopped = b_stop;
    rsp.frame_end    = b_fend && rsp_last;
    rsp.run_last     = rsp_last;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      inq <= req;
    end
    if (fire) begin
      b_byte  <= inq.data_byte;
      b_four  <= emit_four;
      b_codec <= codec_seen_next;
      b_type  <= current_type_next;
      b_param <= current_param_next;
      b_ready <= ready_next;
      b_stop  <= stopped_next;
      b_fend  <= (bytes_left_next == '0);
    end
  end

  // control and scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      has_time_prefix <= 1'b0;
      inq_valid       <= 1'b0;
      rsp_valid       <= 1'b0;
      idx             <= 2'd0;
      codec_seen      <= CODEC_UNKNOWN;
      bytes_left      <= '0;
      prefix_left     <= '0;
      length_phase    <= '0;
      length_bytes    <= '0;
      unit_left       <= '0;
      current_type    <= '0;
      current_param   <= PARAM_NONE;
      stopped         <= 1'b0;
      have_vps        <= 1'b0;
      have_sps        <= 1'b0;
      have_pps        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        has_time_prefix <= cfg_data;
      end
      if (req_valid && !req_stall) begin
        inq_valid <= 1'b1;
      end else if (fire) begin
        inq_valid <= 1'b0;
      end
      if (fire) begin
        rsp_valid     <= emit;
        idx           <= 2'd0;
        codec_seen    <= codec_seen_next;
        bytes_left    <= bytes_left_next;
        prefix_left   <= prefix_left_next;
        length_phase  <= length_phase_next;
        length_bytes  <= length_bytes_next;
        unit_left     <= unit_left_next;
        current_type  <= current_type_next;
        current_param <= current_param_next;
        stopped       <= stopped_next;
        have_vps      <= have_vps_next;
        have_sps      <= have_sps_next;
        have_pps      <= have_pps_next;
      end else if (rsp_valid && !rsp_stall) begin
        if (rsp_last) begin
          rsp_valid <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  // single results never step past the first slot
  a_single_idx: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !b_four) |-> (idx == 2'd0))
    else $error("single result with nonzero index");

  // a unit never reaches past the end of its frame
  a_unit_in_frame: assert property (@(posedge clk) disable iff (rst)
    unit_left <= bytes_left)
    else $error("unit runs past frame end");

  // the time prefix is only skipped before any unit parsing starts
  a_prefix_first: assert property (@(posedge clk) disable iff (rst)
    (prefix_left != 4'd0) |-> (length_phase == 3'd0 && unit_left == '0))
    else $error("prefix skip overlaps unit parsing");

  // under HEVC a stopped frame gives no more results
  a_hevc_stop_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.scan_stopped) |-> (rsp.codec_kind != CODEC_HEVC))
    else $error("result after stop under HEVC");

endmodule
`default_nettype wire

### design/avnal_hdr_class.sv
`default_nettype none
module avnal_hdr_class
  import avnal_pkg::*;
(
  input  wire logic [7:0] hdr,
  input  wire logic [1:0] codec_seen,
  output hdr_info_t       info
);

  logic [5:0] hevc_type;
  logic [4:0] avc_type;
  logic       hevc;

  always_comb begin
    hevc_type = hdr[6:1];
    avc_type  = hdr[4:0];
    info.codec_kind = codec_seen;
    // codec is sniffed only while still unknown
    if (codec_seen == CODEC_UNKNOWN) begin
      if (hevc_type >= HEVC_VPS_TYPE && hevc_type <= HEVC_PPS_TYPE) begin
        info.codec_kind = CODEC_HEVC;
      end else if (!hdr[7] && (avc_type == AVC_SPS_TYPE || avc_type == AVC_PPS_TYPE)) begin
        info.codec_kind = CODEC_H264;
      end
    end
    hevc = (info.codec_kind == CODEC_HEVC);
    info.unit_type = hevc ? hevc_type : {1'b0, avc_type};
    if (hevc && hevc_type == HEVC_VPS_TYPE) begin
      info.param_kind = PARAM_VPS;
    end else if (hevc ? (hevc_type == HEVC_SPS_TYPE) : (avc_type == AVC_SPS_TYPE)) begin
      info.param_kind = PARAM_SPS;
    end else if (hevc ? (hevc_type == HEVC_PPS_TYPE) : (avc_type == AVC_PPS_TYPE)) begin
      info.param_kind = PARAM_PPS;
    end else begin
      info.param_kind = PARAM_NONE;
    end
  end

endmodule
`default_nettype wire

### tb/sv/avcc_nal_scanner_annexb_converter_unit_tb.sv
`timescale 1ns / 100ps

module avcc_nal_scanner_annexb_converter_unit_tb;
  import avnal_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 16;
  localparam int PHASE_ITEMS  = 80;
  localparam int SHOW_ERRORS  = 10;

  // byte scanner predictor plus the queue of output bytes still due
  class annexb_scoreboard;
    bit          prefix_on;
    logic [1:0]  codec;
    logic [23:0] bytes_left;
    logic [3:0]  prefix_left;
    logic [2:0]  len_phase;
    logic [31:0] len_acc;
    logic [31:0] unit_left;
    logic [5:0]  cur_type;
    logic [1:0]  cur_param;
    bit          stopped;
    bit          have_vps;
    bit          have_sps;
    bit          have_pps;
    rsp_item_t   due_out[$];
    int          errors;

    function void clear_frame();
      bytes_left  = '0;
      prefix_left = '0;
      len_phase   = '0;
      len_acc     = '0;
      unit_left   = '0;
      cur_type    = '0;
      cur_param   = PARAM_NONE;
      stopped     = 1'b0;
    endfunction

    function void clear_stream();
      clear_frame();
      codec    = CODEC_UNKNOWN;
      have_vps = 1'b0;
      have_sps = 1'b0;
      have_pps = 1'b0;
    endfunction

    function new();
      prefix_on = 1'b0;
      errors    = 0;
      clear_stream();
    endfunction

    function void classify_header(logic [7:0] hdr);
      logic [5:0] t;
      logic [5:0] sps_t;
      logic [5:0] pps_t;
      bit         hevc;
      // codec is sniffed only while still unknown
      if (codec == CODEC_UNKNOWN) begin
        if (hdr[6:1] >= HEVC_VPS_TYPE && hdr[6:1] <= HEVC_PPS_TYPE)
          codec = CODEC_HEVC;
        else if (!hdr[7] && (hdr[4:0] == AVC_SPS_TYPE || hdr[4:0] == AVC_PPS_TYPE))
          codec = CODEC_H264;
      end
      hevc  = (codec == CODEC_HEVC);
      t     = hevc ? hdr[6:1] : {1'b0, hdr[4:0]};
      sps_t = hevc ? HEVC_SPS_TYPE : {1'b0, AVC_SPS_TYPE};
      pps_t = hevc ? HEVC_PPS_TYPE : {1'b0, AVC_PPS_TYPE};
      cur_type = t;
      if (hevc && t == HEVC_VPS_TYPE) begin
        cur_param = PARAM_VPS;
        have_vps  = 1'b1;
      end else if (t == sps_t) begin
        cur_param = PARAM_SPS;
        have_sps  = 1'b1;
      end else if (t == pps_t) begin
        cur_param = PARAM_PPS;
        have_pps  = 1'b1;
      end else begin
        cur_param = PARAM_NONE;
      end
    endfunction

    // one accepted item in, zero to four output bytes queued
    function void scan_item(req_item_t it);
      logic [7:0]  vals[$];
      logic [7:0]  b;
      logic [23:0] rem;
      bit          hevc;
      bit          last;
      rsp_item_t   r;
      b = it.data_byte;
      if (it.req_type == REQ_CLEAR) begin
        clear_stream();
        return;
      end
      if (it.first_of_frame) begin
        clear_frame();
        bytes_left  = it.frame_bytes;
        prefix_left = prefix_on ? PREFIX_LEN : 4'd0;
      end
      if (bytes_left == 0) return;
      rem = bytes_left;
      bytes_left--;
      if (prefix_left != 0) begin
        prefix_left--;
        return;
      end
      hevc = (codec == CODEC_HEVC);
      if (stopped || (unit_left == 0 && len_phase == 0 && rem < 4)) begin
        if (!hevc) vals.push_back(b);
      end else if (unit_left == 0) begin
        if (len_phase == 0) begin
          cur_type  = '0;
          cur_param = PARAM_NONE;
        end
        len_acc = {len_acc[23:0], b};
        len_phase++;
        if (!hevc) vals.push_back(b);
        if (len_phase >= PHASE_HEADER) begin
          if (len_acc == 0 || len_acc > {8'd0, bytes_left}) begin
            stopped   = 1'b1;
            len_phase = '0;
          end else begin
            unit_left = len_acc;
            len_phase = PHASE_HEADER;
            if (hevc) begin
              vals.push_back(START_CODE_ZERO);
              vals.push_back(START_CODE_ZERO);
              vals.push_back(START_CODE_ZERO);
              vals.push_back(START_CODE_ONE);
            end
          end
          len_acc = '0;
        end
      end else if (len_phase == PHASE_HEADER) begin
        classify_header(b);
        len_phase = '0;
        unit_left--;
        vals.push_back(b);
      end else begin
        unit_left--;
        vals.push_back(b);
      end
      foreach (vals[k]) begin
        last           = (k == vals.size() - 1);
        r.out_byte     = vals[k];
        r.codec_kind   = codec;
        r.unit_type    = cur_type;
        r.param_kind   = cur_param;
        r.sets_ready   = have_sps && have_pps && (codec != CODEC_HEVC || have_vps);
        r.scan_stopped = stopped;
        r.frame_end    = last && (bytes_left == 0);
        r.run_last     = last;
        due_out.push_back(r);
      end
    endfunction

    function string show(rsp_item_t r);
      return $sformatf("byte %h codec %0d type %0d param %0d ready %b stop %b end %b last %b",
                       r.out_byte, r.codec_kind, r.unit_type, r.param_kind, r.sets_ready,
                       r.scan_stopped, r.frame_end, r.run_last);
    endfunction

    function void check_out(rsp_item_t got);
      rsp_item_t want;
      if (due_out.size() == 0) begin
        errors++;
        if (errors <= SHOW_ERRORS)
          $display("unexpected output item: %s", show(got));
        return;
      end
      want = due_out.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= SHOW_ERRORS) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_item_t rsp;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  annexb_scoreboard sb;
  int               cycles;
  int               items_sent;
  int               send_idle_pct;
  int               recv_stall_pct;

  // frame under construction
  logic [7:0]  frm_q[$];
  logic [23:0] frm_len;

  avcc_nal_scanner_annexb_converter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver back-pressure, changed only at the falling edge
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // both channels sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.scan_item(req);
      if (rsp_valid && !rsp_stall) sb.check_out(rsp);
    end
  end

  function automatic req_item_t mk_item(logic rt, logic [7:0] data, logic first,
                                        logic [23:0] fb);
    req_item_t it;
    it.req_type       = rt;
    it.data_byte      = data;
    it.first_of_frame = first;
    it.frame_bytes    = fb;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input req_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // drop valid, let every due output item arrive, then let in-flight work settle
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (sb.due_out.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  task automatic write_prefix(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.prefix_on = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // nal header byte, leaning toward one codec family
  function automatic logic [7:0] pick_header(int fam);
    int sel;
    sel = $urandom_range(0, 9);
    if (fam == 0) begin
      case (sel)
        0: return {1'b0, HEVC_VPS_TYPE, 1'b0};
        1: return {1'b0, HEVC_SPS_TYPE, 1'b0};
        2: return {1'b0, HEVC_PPS_TYPE, 1'b0};
        3, 4, 5: return {1'b0, 1'b0, 5'($urandom), 1'($urandom)};
        default: return 8'($urandom);
      endcase
    end else begin
      case (sel)
        0: return {3'b011, AVC_SPS_TYPE};
        1: return {3'b011, AVC_PPS_TYPE};
        2: return {1'b1, 2'($urandom), AVC_SPS_TYPE};  // forbidden bit set
        3, 4, 5: return {1'b0, 2'($urandom), 5'($urandom_range(1, 6))};
        default: return 8'($urandom);
      endcase
    end
  endfunction

  // builds one frame into frm_q, mostly well-formed, sometimes broken
  function automatic void build_frame(input bit with_prefix, input int fam);
    int          n_units;
    int          plen;
    int          tail;
    int          flaw;
    logic [31:0] ulen;
    frm_q.delete();
    if (with_prefix) repeat (8) frm_q.push_back(8'($urandom));
    n_units = $urandom_range(1, 3);
    for (int u = 0; u < n_units; u++) begin
      plen = $urandom_range(0, 4);
      if ($urandom_range(0, 15) == 0) plen = $urandom_range(5, 40);
      ulen = plen + 1;
      for (int s = 3; s >= 0; s--) frm_q.push_back(ulen[s*8 +: 8]);
      frm_q.push_back(pick_header(fam));
      repeat (plen) frm_q.push_back(8'($urandom));
    end
    flaw = $urandom_range(0, 9);
    tail = $urandom_range(0, 3);
    case (flaw)
      7: begin
        // zero length field
        repeat (4) frm_q.push_back(8'h00);
        repeat (tail) frm_q.push_back(8'($urandom));
      end
      8: begin
        // length longer than what follows
        ulen = $urandom_range(0, 1) ? $urandom : tail + 1 + $urandom_range(0, 2);
        for (int s = 3; s >= 0; s--) frm_q.push_back(ulen[s*8 +: 8]);
        repeat (tail) frm_q.push_back(8'($urandom));
      end
      9: begin
        // short tail where a length field would start
        repeat ($urandom_range(1, 3)) frm_q.push_back(8'($urandom));
      end
      default: ;
    endcase
    frm_len = 24'(frm_q.size());
    // declared size off from the real one now and then
    if ($urandom_range(0, 7) == 0) frm_len = 24'($urandom_range(1, frm_q.size() + 3));
  endfunction

  task automatic send_frame();
    foreach (frm_q[i])
      send_item(mk_item(REQ_BYTE, frm_q[i], i == 0, (i == 0) ? frm_len : 24'($urandom)));
  endtask

  task automatic run_phase(input int s_pct, input int r_pct);
    int sel;
    int fam;
    int stop_at;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    fam            = $urandom_range(0, 1);
    stop_at        = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        // new sender: clear the stream and maybe switch codec family
        send_item(mk_item(REQ_CLEAR, 8'($urandom), 1'($urandom), 24'($urandom)));
        fam = $urandom_range(0, 1);
      end else if (sel < 4) begin
        // stray bytes, sometimes opening an oversized frame
        repeat ($urandom_range(1, 3))
          send_item(mk_item(REQ_BYTE, 8'($urandom), $urandom_range(0, 3) == 0,
                            24'($urandom)));
      end else begin
        build_frame(sb.prefix_on, fam);
        send_frame();
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    rsp_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = 1'b0;
    cycles         = 0;
    items_sent     = 0;
    send_idle_pct  = 7;
    recv_stall_pct = 79;
    sb             = new();

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_prefix(1'b0);

    // directed: clear with every field high, stray byte, empty frame
    send_item(mk_item(REQ_CLEAR, 8'hFF, 1'b1, 24'hFF_FFFF));
    send_item(mk_item(REQ_BYTE, 8'h00, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h5A, 1'b1, 24'h00_0000));

    // largest frame size, codec still unknown: unit passes through, then an
    // all-ones length stops the scan and the rest passes unchanged
    send_item(mk_item(REQ_BYTE, 8'h00, 1'b1, 24'hFF_FFFF));
    send_item(mk_item(REQ_BYTE, 8'h00, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h00, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h03, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h01, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h80, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'hFF, 1'b0, 24'h00_0000));
    repeat (4) send_item(mk_item(REQ_BYTE, 8'hFF, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h5A, 1'b0, 24'h00_0000));

    // new frame cuts the old one short; a vps header decides hevc mid-frame,
    // then a zero length under hevc drops the rest
    send_item(mk_item(REQ_BYTE, 8'h00, 1'b1, 24'd10));
    send_item(mk_item(REQ_BYTE, 8'h00, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h00, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h01, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, {1'b0, HEVC_VPS_TYPE, 1'b0}, 1'b0, 24'h00_0000));
    repeat (4) send_item(mk_item(REQ_BYTE, 8'h00, 1'b0, 24'h00_0000));
    send_item(mk_item(REQ_BYTE, 8'h11, 1'b0, 24'h00_0000));
    wait_idle();

    // random traffic: sender mostly busy, receiver mostly stalled
    write_prefix(1'b1);
    run_phase(7, 79);
    wait_idle();

    // sender mostly idle, receiver mostly ready
    write_prefix(1'b0);
    run_phase(79, 7);
    wait_idle();

    // full rate both ways
    write_prefix(1'b1);
    run_phase(0, 0);
    wait_idle();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
